@@ hw/rtl/matrix4_multiply_core_assert.svh @@
// Assertion macros for the checker file.
`ifndef MATRIX4_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX4_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define M4_ASSERT_NOW(label, prop_clk, prop_rst_n, ante, cons) \
    label: assert property (@(posedge prop_clk) disable iff (!prop_rst_n) \
        (ante) |-> (cons)) else $error("matrix4 core: assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define M4_ASSERT_NEXT(label, prop_clk, prop_rst_n, ante, cons) \
    label: assert property (@(posedge prop_clk) disable iff (!prop_rst_n) \
        (ante) |=> (cons)) else $error("matrix4 core: assertion failed");

`endif

@@ hw/rtl/m4mul_pkg.sv @@
package m4mul_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int ELEM_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int DIM         = 4;
    localparam int IDX_WIDTH   = 2;
    localparam int CNT_WIDTH   = 2 * IDX_WIDTH;
    localparam int ELEM_COUNT  = DIM * DIM;

    typedef enum logic [1:0] {
        OP_WRITE_FIRST  = 2'd0,
        OP_WRITE_SECOND = 2'd1,
        OP_COMPUTE      = 2'd2
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        opcode_t                        opcode;
        logic [IDX_WIDTH-1:0]           column_index;
        logic [IDX_WIDTH-1:0]           row_index;
        logic signed [DATA_WIDTH-1:0]   element_value;
    } in_t;

    typedef struct packed {
        logic [IDX_WIDTH-1:0]           out_column;
        logic [IDX_WIDTH-1:0]           out_row;
        logic signed [DATA_WIDTH-1:0]   product_value;
        logic                           last_element;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   wr_first;
        logic                   wr_second;
        logic [IDX_WIDTH-1:0]   wr_col;
        logic [IDX_WIDTH-1:0]   wr_row;
        logic                   rd_en;
        logic [IDX_WIDTH-1:0]   rd_col;
        logic [IDX_WIDTH-1:0]   rd_row;
        logic                   rd_last;
    } cmd_t;

endpackage

@@ hw/rtl/m4mul_ram.sv @@
module m4mul_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/m4mul_ctrl.sv @@
module m4mul_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  m4mul_pkg::opcode_t opcode,
    input  logic [m4mul_pkg::IDX_WIDTH-1:0] column_index,
    input  logic [m4mul_pkg::IDX_WIDTH-1:0] row_index,
    output logic               busy,
    output m4mul_pkg::cmd_t    cmd
);

    m4mul_pkg::state_t                    state_reg;
    m4mul_pkg::state_t                    state_next;
    logic [m4mul_pkg::CNT_WIDTH-1:0]      cnt_reg;
    logic [m4mul_pkg::CNT_WIDTH-1:0]      cnt_next;
    logic                                 accept;
    logic                                 cnt_end;

    localparam logic [m4mul_pkg::CNT_WIDTH-1:0] CNT_LAST =
        m4mul_pkg::CNT_WIDTH'(m4mul_pkg::ELEM_COUNT - 1);

    assign accept  = start && (state_reg == m4mul_pkg::ST_IDLE);
    assign cnt_end = (cnt_reg == CNT_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= m4mul_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and element counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            m4mul_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && opcode == m4mul_pkg::OP_COMPUTE)
                begin
                    state_next = m4mul_pkg::ST_RUN;
                end
            end
            m4mul_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + m4mul_pkg::CNT_WIDTH'(1);
                if (cnt_end)
                begin
                    state_next = m4mul_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy          = 1'b0;
        cmd.wr_first  = 1'b0;
        cmd.wr_second = 1'b0;
        cmd.wr_col    = column_index;
        cmd.wr_row    = row_index;
        cmd.rd_en     = 1'b0;
        cmd.rd_col    = cnt_reg[m4mul_pkg::CNT_WIDTH-1:m4mul_pkg::IDX_WIDTH];
        cmd.rd_row    = cnt_reg[m4mul_pkg::IDX_WIDTH-1:0];
        cmd.rd_last   = cnt_end;
        unique case (state_reg)
            m4mul_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        m4mul_pkg::OP_WRITE_FIRST:  cmd.wr_first  = 1'b1;
                        m4mul_pkg::OP_WRITE_SECOND: cmd.wr_second = 1'b1;
                        default:                    ;
                    endcase
                end
            end
            m4mul_pkg::ST_RUN:
            begin
                busy      = 1'b1;
                cmd.rd_en = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/m4mul_datapath.sv @@
module m4mul_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  m4mul_pkg::cmd_t                       cmd,
    input  logic signed [m4mul_pkg::DATA_WIDTH-1:0] wr_data,
    output logic                                  result_valid,
    output m4mul_pkg::out_t                       result
);

    localparam int EW = m4mul_pkg::ELEM_WIDTH;
    localparam int PW = m4mul_pkg::PROD_WIDTH;
    localparam int AW = m4mul_pkg::ACC_WIDTH;
    localparam int IW = m4mul_pkg::IDX_WIDTH;
    localparam int N  = m4mul_pkg::DIM;

    localparam logic signed [AW-1:0] SAT_MAX = (AW'(1) <<< (EW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

    // Valid bits stand in for the reset-time clear of both stores.
    logic [m4mul_pkg::ELEM_COUNT-1:0] fvld_reg;
    logic [m4mul_pkg::ELEM_COUNT-1:0] svld_reg;
    logic [N-1:0]                     fmask_reg;
    logic [N-1:0]                     smask_reg;

    logic [EW-1:0]          frd_data [N];
    logic [EW-1:0]          srd_data [N];
    logic signed [EW-1:0]   fop [N];
    logic signed [EW-1:0]   sop [N];
    logic signed [PW-1:0]   prod_reg [N];
    logic signed [AW-1:0]   sum_reg;
    logic signed [AW-1:0]   sum_next;
    logic signed [AW-1:0]   shifted;
    logic signed [EW-1:0]   sat_val;

    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [IW-1:0] s1_col_reg, s2_col_reg, s3_col_reg;
    logic [IW-1:0] s1_row_reg, s2_row_reg, s3_row_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg;

    logic            result_valid_reg;
    m4mul_pkg::out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg <= '0;
            svld_reg <= '0;
        end
        else
        begin
            if (cmd.wr_first)
            begin
                fvld_reg[{cmd.wr_col, cmd.wr_row}] <= 1'b1;
            end
            if (cmd.wr_second)
            begin
                svld_reg[{cmd.wr_col, cmd.wr_row}] <= 1'b1;
            end
        end
    end

    // First operand banked by column, second operand banked by row, so one
    // result element reads all four terms of its dot product at once.
    for (genvar k = 0; k < N; k++)
    begin : g_bank
        localparam logic [IW-1:0] K = IW'(k);

        m4mul_ram #(
            .WIDTH (EW),
            .DEPTH (N)
        ) u_first_ram (
            .clk     (clk),
            .wr_en   (cmd.wr_first && cmd.wr_col == K),
            .wr_addr (cmd.wr_row),
            .wr_data (wr_data[EW-1:0]),
            .rd_en   (cmd.rd_en),
            .rd_addr (cmd.rd_row),
            .rd_data (frd_data[k])
        );

        m4mul_ram #(
            .WIDTH (EW),
            .DEPTH (N)
        ) u_second_ram (
            .clk     (clk),
            .wr_en   (cmd.wr_second && cmd.wr_row == K),
            .wr_addr (cmd.wr_col),
            .wr_data (wr_data[EW-1:0]),
            .rd_en   (cmd.rd_en),
            .rd_addr (cmd.rd_col),
            .rd_data (srd_data[k])
        );

        always_ff @(posedge clk)
        begin
            if (cmd.rd_en)
            begin
                fmask_reg[k] <= fvld_reg[{K, cmd.rd_row}];
                smask_reg[k] <= svld_reg[{cmd.rd_col, K}];
            end
        end

        assign fop[k] = fmask_reg[k] ? signed'(frd_data[k]) : '0;
        assign sop[k] = smask_reg[k] ? signed'(srd_data[k]) : '0;

        always_ff @(posedge clk)
        begin
            prod_reg[k] <= PW'(fop[k]) * PW'(sop[k]);
        end
    end

    assign sum_next = AW'(prod_reg[0]) + AW'(prod_reg[1])
                    + AW'(prod_reg[2]) + AW'(prod_reg[3]);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign shifted = sum_reg >>> m4mul_pkg::FRAC_BITS;

    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            sat_val = SAT_MAX[EW-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            sat_val = SAT_MIN[EW-1:0];
        end
        else
        begin
            sat_val = shifted[EW-1:0];
        end
    end

    // Element tags ride alongside the arithmetic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            s3_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg       <= cmd.rd_en;
            s2_vld_reg       <= s1_vld_reg;
            s3_vld_reg       <= s2_vld_reg;
            result_valid_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg  <= cmd.rd_col;
        s1_row_reg  <= cmd.rd_row;
        s1_last_reg <= cmd.rd_last;
        s2_col_reg  <= s1_col_reg;
        s2_row_reg  <= s1_row_reg;
        s2_last_reg <= s1_last_reg;
        s3_col_reg  <= s2_col_reg;
        s3_row_reg  <= s2_row_reg;
        s3_last_reg <= s2_last_reg;
        result_reg.out_column    <= s3_col_reg;
        result_reg.out_row       <= s3_row_reg;
        result_reg.product_value <= m4mul_pkg::DATA_WIDTH'(sat_val);
        result_reg.last_element  <= s3_last_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hw/rtl/matrix4_multiply_core.sv @@
// Channel   Handshake             Payload                Notes
// request   start / busy          m4mul_pkg::in_t        beat taken when start && !busy
// result    result_valid strobe   m4mul_pkg::out_t       no back-pressure
//
// After a write beat, another beat can follow in the next cycle.
// A compute beat holds busy while the counter walks the 16 elements, one per cycle,
// through RAM read, four 32x32 multipliers, then product, sum and result registers.
// Reset clears both operand stores to zero through per-entry valid bits; no sweep.
// The receiver cannot stall: each result beat shows for exactly one cycle.
module matrix4_multiply_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  m4mul_pkg::in_t   request,
    output logic             busy,
    output logic             result_valid,
    output m4mul_pkg::out_t  result
);

    m4mul_pkg::cmd_t cmd;

    m4mul_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (request.opcode),
        .column_index (request.column_index),
        .row_index    (request.row_index),
        .busy         (busy),
        .cmd          (cmd)
    );

    m4mul_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .wr_data      (request.element_value),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ hw/rtl/m4mul_checker.sv @@
`include "matrix4_multiply_core_assert.svh"

module m4mul_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input m4mul_pkg::in_t   request,
    input logic             busy,
    input logic             result_valid,
    input m4mul_pkg::out_t  result
);

    `M4_ASSERT_NOW(a_last_at_corner, clk, rst_n, result_valid && result.last_element, result.out_column == 2'd3 && result.out_row == 2'd3)
    `M4_ASSERT_NEXT(a_run_unbroken, clk, rst_n, result_valid && !result.last_element, result_valid)
    `M4_ASSERT_NEXT(a_row_order, clk, rst_n, result_valid && result.out_row != 2'd3, result.out_column == $past(result.out_column) && result.out_row == $past(result.out_row) + 2'd1)
    `M4_ASSERT_NEXT(a_compute_busy, clk, rst_n, start && !busy && request.opcode == m4mul_pkg::OP_COMPUTE, busy)

endmodule

bind matrix4_multiply_core m4mul_checker u_checker (.*);

@@ tb/sv/matrix4_multiply_core_tb.sv @@
`timescale 1ns / 100ps

module matrix4_multiply_core_tb;

    import m4mul_pkg::*;

    localparam int     QUIET_LIMIT = 500;
    localparam int     TAIL_CYCLES = 30;
    localparam int     MAX_GAP     = 20;
    localparam opcode_t OP_UNUSED  = opcode_t'(2'd3);

    class matrix_product_tracker;
        logic signed [ELEM_WIDTH-1:0] first_store  [ELEM_COUNT];
        logic signed [ELEM_WIDTH-1:0] second_store [ELEM_COUNT];
        out_t expected_products [$];
        int errors;
        int writes_seen;
        int runs_seen;
        int ignored_seen;
        int results_seen;

        function new();
            foreach (first_store[i])
            begin
                first_store[i]  = '0;
                second_store[i] = '0;
            end
            errors       = 0;
            writes_seen  = 0;
            runs_seen    = 0;
            ignored_seen = 0;
            results_seen = 0;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Exact sum of four full products, floor-shifted, then saturated.
        function logic signed [DATA_WIDTH-1:0] dot_column_row(int c, int r);
            logic signed [ACC_WIDTH-1:0] acc;
            logic signed [ACC_WIDTH-1:0] scaled;
            logic signed [ACC_WIDTH-1:0] hi_lim;
            logic signed [ACC_WIDTH-1:0] lo_lim;
            longint term;
            acc = '0;
            for (int k = 0; k < DIM; k++)
            begin
                term = longint'(first_store[k * DIM + r]) * longint'(second_store[c * DIM + k]);
                acc  = acc + term;
            end
            scaled = acc >>> FRAC_BITS;
            hi_lim = {{(ACC_WIDTH - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}};
            lo_lim = -hi_lim - 1;
            if (scaled > hi_lim)
                scaled = hi_lim;
            if (scaled < lo_lim)
                scaled = lo_lim;
            return scaled[DATA_WIDTH-1:0];
        endfunction

        function void note_beat(in_t beat);
            int   addr;
            out_t elem;
            addr = beat.column_index * DIM + beat.row_index;
            case (beat.opcode)
                OP_WRITE_FIRST:
                begin
                    first_store[addr] = beat.element_value[ELEM_WIDTH-1:0];
                    writes_seen++;
                end
                OP_WRITE_SECOND:
                begin
                    second_store[addr] = beat.element_value[ELEM_WIDTH-1:0];
                    writes_seen++;
                end
                OP_COMPUTE:
                begin
                    runs_seen++;
                    for (int c = 0; c < DIM; c++)
                    begin
                        for (int r = 0; r < DIM; r++)
                        begin
                            elem.out_column    = IDX_WIDTH'(c);
                            elem.out_row       = IDX_WIDTH'(r);
                            elem.product_value = dot_column_row(c, r);
                            elem.last_element  = (c == DIM - 1) && (r == DIM - 1);
                            expected_products.push_back(elem);
                        end
                    end
                end
                default:
                    ignored_seen++;
            endcase
        endfunction

        task check_beat(out_t got);
            out_t want;
            results_seen++;
            if (expected_products.size() == 0)
            begin
                report($sformatf("result beat col %0d row %0d value %h with nothing pending",
                                 got.out_column, got.out_row, got.product_value));
                return;
            end
            want = expected_products.pop_front();
            if (got.out_column !== want.out_column)
                report($sformatf("out_column %0d, want %0d", got.out_column, want.out_column));
            if (got.out_row !== want.out_row)
                report($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
            if (got.product_value !== want.product_value)
                report($sformatf("product_value[%0d][%0d] %h, want %h", want.out_column,
                                 want.out_row, got.product_value, want.product_value));
            if (got.last_element !== want.last_element)
                report($sformatf("last_element %b, want %b at [%0d][%0d]", got.last_element,
                                 want.last_element, want.out_column, want.out_row));
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    in_t   request;
    logic  busy;
    logic  result_valid;
    out_t  result;

    matrix_product_tracker tracker = new();
    bit    took_beat;
    int    quiet_cycles;

    matrix4_multiply_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample at the rising edge, before the block's flops update.
    always @(posedge clk)
    begin
        took_beat = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                took_beat = 1'b1;
                tracker.note_beat(request);
            end
            if (result_valid)
                tracker.check_beat(result);
            if (took_beat || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic in_t make_beat(opcode_t op, int c, int r, logic [DATA_WIDTH-1:0] v);
        in_t beat;
        beat.opcode        = op;
        beat.column_index  = IDX_WIDTH'(c);
        beat.row_index     = IDX_WIDTH'(r);
        beat.element_value = v;
        return beat;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic in_t random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return make_beat(OP_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom());
        if (pick < 16)
            return make_beat(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3), $urandom());
        return make_beat(pick[0] ? OP_WRITE_FIRST : OP_WRITE_SECOND,
                         $urandom_range(0, 3), $urandom_range(0, 3), pick_element());
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task send_beat(in_t beat, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= beat;
        do
            @(negedge clk);
        while (!took_beat);
    endtask

    initial
    begin
        int idle_pct [3];
        int gap;
        idle_pct = '{0, 67, 27};
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        took_beat    = 1'b0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stores come out of reset as zero.
        send_beat(make_beat(OP_COMPUTE, 0, 0, 32'h0), 0);
        // Positive and negative overflow, and min times min.
        send_beat(make_beat(OP_WRITE_FIRST,  0, 0, 32'h7FFF_FFFF), 0);
        send_beat(make_beat(OP_WRITE_SECOND, 0, 0, 32'h7FFF_FFFF), 0);
        send_beat(make_beat(OP_WRITE_FIRST,  1, 1, 32'h8000_0000), 0);
        send_beat(make_beat(OP_WRITE_SECOND, 1, 1, 32'h7FFF_FFFF), 0);
        send_beat(make_beat(OP_WRITE_FIRST,  2, 2, 32'h8000_0000), 0);
        send_beat(make_beat(OP_WRITE_SECOND, 2, 2, 32'h8000_0000), 0);
        // Smallest negative product must floor to -1.
        send_beat(make_beat(OP_WRITE_FIRST,  3, 3, 32'hFFFF_FFFF), 0);
        send_beat(make_beat(OP_WRITE_SECOND, 3, 3, 32'h0000_0001), 0);
        send_beat(make_beat(OP_WRITE_FIRST,  0, 3, 32'h0001_0000), 0);
        send_beat(make_beat(OP_WRITE_SECOND, 3, 0, 32'hFFFF_0000), 0);
        // Unused opcode must leave the stores alone.
        send_beat(make_beat(OP_UNUSED, 0, 0, 32'h1234_5678), 0);
        send_beat(make_beat(OP_UNUSED, 3, 3, 32'hFFFF_FFFF), 0);
        // Compute ignores its index and value fields.
        send_beat(make_beat(OP_COMPUTE, 3, 3, 32'hFFFF_FFFF), 0);
        send_beat(make_beat(OP_WRITE_FIRST,  3, 0, 32'h0002_8000), 0);
        send_beat(make_beat(OP_WRITE_SECOND, 0, 3, 32'hFFFE_8000), 0);
        send_beat(make_beat(OP_COMPUTE, 1, 2, 32'h5555_AAAA), 0);
        send_beat(make_beat(OP_COMPUTE, 2, 1, 32'hAAAA_5555), 3);

        foreach (idle_pct[p])
        begin
            for (int i = 0; i < 44; i++)
            begin
                // Idle each cycle with the phase's odds until a beat is sent or the gap reaches its cap.
                gap = 0;
                while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct[p])
                    gap++;
                send_beat(random_beat(), gap);
            end
            send_beat(make_beat(OP_COMPUTE, 0, 0, 32'h0), 0);
        end
        start <= 1'b0;

        while (tracker.expected_products.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d request beats: %0d element writes, %0d compute runs, %0d ignored.",
                 tracker.writes_seen + tracker.runs_seen + tracker.ignored_seen,
                 tracker.writes_seen, tracker.runs_seen, tracker.ignored_seen);
        $display("Checked %0d result beats, %0d mismatches.", tracker.results_seen,
                 tracker.errors);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
